// File: rtl/core/pmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants of the priority message queue.
// Holds the request and result words, the codes and the queue geometry.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int QueueDepth = 16;
    localparam int CountW     = 11;
    localparam int SizeW      = 21;

    localparam logic [CountW-1:0] MaxMessagesReset = 11'd10;
    localparam logic [SizeW-1:0]  MaxSizeReset     = 21'd8192;
    localparam logic [6:0]        SigMax           = 7'd64;

    localparam logic [CountW-1:0] DepthCount = CountW'(QueueDepth);

    typedef enum logic [1:0] {
        REQ_SEND       = 2'd0,
        REQ_RECEIVE    = 2'd1,
        REQ_NOTIFY_REG = 2'd2,
        REQ_NOTIFY_UNR = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_MSGSIZE = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_BUSY    = 3'd5
    } t_status;

    localparam logic [1:0] KIND_SIGNAL = 2'd0;
    localparam logic [1:0] KIND_NONE   = 2'd1;

    localparam logic [0:0] ADDR_MAX_MESSAGES = 1'b0;
    localparam logic [0:0] ADDR_MAX_SIZE     = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [15:0]      priority_req;
        logic [SizeW-1:0] length;
        logic [63:0]      payload;
        logic [15:0]      task_id;
        logic [1:0]       notify_kind;
        logic [6:0]       signal_number;
    } t_req_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [63:0]       out_payload;
        logic [14:0]       out_priority;
        logic [SizeW-1:0]  out_length;
        logic              notify_fire;
        logic [15:0]       notify_task;
        logic [6:0]        notify_signal;
        logic [CountW-1:0] message_count;
    } t_res_word;

    // Classified command passed from front to back.
    typedef struct packed {
        logic              is_queue_op; // send or receive that touches the queue
        logic              is_send;
        logic [2:0]        status;      // final status for non-queue ops
        logic [14:0]       prio;
        logic [SizeW-1:0]  length;
        logic [63:0]       payload;
        logic              fire;
        logic [15:0]       notify_task;
        logic [6:0]        notify_signal;
    } t_cmd;

endpackage

// File: rtl/core/pmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_front: request checker.
// Checks each request against the registers, count and notification owner,
// updates the owner and count, and hands a classified command to the back.
// ----------------------------------------------------------------------------
module pmq_front import pmq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_req_word         i_req,
    input  logic [CountW-1:0] i_max_messages,
    input  logic [SizeW-1:0]  i_max_size,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    output logic [CountW-1:0] o_count
);

    logic              r_owner_valid, n_owner_valid;
    logic [15:0]       r_owner_task, n_owner_task;
    logic [6:0]        r_owner_signal, n_owner_signal;
    logic [CountW-1:0] r_count, n_count;
    logic [CountW-1:0] cap;
    t_cmd              cmd;

    assign cap = (i_max_messages > DepthCount) ? DepthCount : i_max_messages;

    // Classify the request and compute owner and count updates.
    always_comb begin
        n_owner_valid  = r_owner_valid;
        n_owner_task   = r_owner_task;
        n_owner_signal = r_owner_signal;
        n_count        = r_count;
        cmd            = '0;
        cmd.prio       = i_req.priority_req[14:0];
        cmd.length     = i_req.length;
        cmd.payload    = i_req.payload;
        unique case (t_req'(i_req.req_type))
            REQ_SEND: begin
                if (i_req.priority_req[15]) begin
                    cmd.status = ST_INVALID;
                end else if (i_req.length > i_max_size) begin
                    cmd.status = ST_MSGSIZE;
                end else if (r_count >= cap) begin
                    cmd.status = ST_FULL;
                end else begin
                    cmd.is_queue_op = 1'b1;
                    cmd.is_send     = 1'b1;
                    n_count         = r_count + 1'b1;
                    if (r_count == '0 && r_owner_valid) begin
                        n_owner_valid = 1'b0;
                        if (r_owner_signal != '0) begin
                            cmd.fire          = 1'b1;
                            cmd.notify_task   = r_owner_task;
                            cmd.notify_signal = r_owner_signal;
                        end
                    end
                end
            end
            REQ_RECEIVE: begin
                if (i_req.length < i_max_size) begin
                    cmd.status = ST_MSGSIZE;
                end else if (r_count == '0) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.is_queue_op = 1'b1;
                    n_count         = r_count - 1'b1;
                end
            end
            REQ_NOTIFY_REG: begin
                if (r_owner_valid && r_owner_task != i_req.task_id) begin
                    cmd.status = ST_BUSY;
                end else if (i_req.notify_kind == KIND_SIGNAL) begin
                    if (i_req.signal_number == '0 || i_req.signal_number > SigMax) begin
                        cmd.status = ST_INVALID;
                    end else begin
                        n_owner_valid  = 1'b1;
                        n_owner_task   = i_req.task_id;
                        n_owner_signal = i_req.signal_number;
                    end
                end else if (i_req.notify_kind == KIND_NONE) begin
                    n_owner_valid  = 1'b1;
                    n_owner_task   = i_req.task_id;
                    n_owner_signal = '0;
                end else begin
                    cmd.status = ST_INVALID;
                end
            end
            REQ_NOTIFY_UNR: begin
                if (r_owner_valid && r_owner_task == i_req.task_id) begin
                    n_owner_valid = 1'b0;
                end
            end
            default: cmd.status = ST_INVALID;
        endcase
    end

    // State and the command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid  <= 1'b0;
            r_owner_task   <= '0;
            r_owner_signal <= '0;
            r_count        <= '0;
            o_cmd_valid    <= 1'b0;
        end else begin
            o_cmd_valid <= i_valid;
            if (i_valid) begin
                r_owner_valid  <= n_owner_valid;
                r_owner_task   <= n_owner_task;
                r_owner_signal <= n_owner_signal;
                r_count        <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            o_cmd   <= cmd;
            o_count <= n_count;
        end
    end

endmodule

// File: rtl/core/pmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_back: sorted shift-register queue.
// Inserts a send after all entries of equal or higher priority, pops the head
// on receive, and registers the result word.
// ----------------------------------------------------------------------------
module pmq_back import pmq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    input  logic [CountW-1:0] i_count,
    output logic              o_res_valid,
    output t_res_word         o_res
);

    logic [14:0]      r_prio [QueueDepth];
    logic [SizeW-1:0] r_len  [QueueDepth];
    logic [63:0]      r_pay  [QueueDepth];
    logic [QueueDepth-1:0] r_occ;
    logic [QueueDepth-1:0] keep;   // entry stays ahead of the new message
    t_res_word        res;

    // Each occupied cell compares its priority with the new one.
    always_comb begin
        for (int i = 0; i < QueueDepth; i++) begin
            keep[i] = r_occ[i] && (r_prio[i] >= i_cmd.prio);
        end
    end

    // Result word.
    always_comb begin
        res               = '0;
        res.status        = i_cmd.status;
        res.notify_fire   = i_cmd.fire;
        res.notify_task   = i_cmd.notify_task;
        res.notify_signal = i_cmd.notify_signal;
        res.message_count = i_count;
        if (i_cmd.is_queue_op && !i_cmd.is_send) begin
            res.out_payload  = r_pay[0];
            res.out_priority = r_prio[0];
            res.out_length   = r_len[0];
        end
    end

    // Occupancy and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= i_cmd_valid;
            if (i_cmd_valid && i_cmd.is_queue_op) begin
                if (i_cmd.is_send) begin
                    r_occ <= {r_occ[QueueDepth-2:0], 1'b1};
                end else begin
                    r_occ <= {1'b0, r_occ[QueueDepth-1:1]};
                end
            end
        end
    end

    // Cell array: shift down on insert, shift up on pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            o_res <= res;
        end
        if (i_cmd_valid && i_cmd.is_queue_op) begin
            for (int i = 0; i < QueueDepth; i++) begin
                if (i_cmd.is_send) begin
                    if (!keep[i]) begin
                        if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
                            r_prio[i] <= i_cmd.prio;
                            r_len[i]  <= i_cmd.length;
                            r_pay[i]  <= i_cmd.payload;
                        end else begin
                            r_prio[i] <= r_prio[(i == 0) ? 0 : i-1];
                            r_len[i]  <= r_len[(i == 0) ? 0 : i-1];
                            r_pay[i]  <= r_pay[(i == 0) ? 0 : i-1];
                        end
                    end
                end else if (i < QueueDepth-1) begin
                    r_prio[i] <= r_prio[(i < QueueDepth-1) ? i+1 : i];
                    r_len[i]  <= r_len[(i < QueueDepth-1) ? i+1 : i];
                    r_pay[i]  <= r_pay[(i < QueueDepth-1) ? i+1 : i];
                end
            end
        end
    end

endmodule

// File: rtl/core/priority_message_queue_core.sv
`timescale 1ns / 1ps
// The request is registered in the front's command register, and the result
// word and its strobe in the back's result register.
// Busy is high for one cycle after each accepted start while the sorted cell
// array takes the command; a start during busy is not accepted.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the queue, drops the notification
// owner and loads the registers with 10 messages and 8192 bytes.
// ----------------------------------------------------------------------------
// priority_message_queue_core: bounded stable priority message queue.
// Front checker, command register and sorted back end with an APB port.
// ----------------------------------------------------------------------------
module priority_message_queue_core import pmq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_req_word    i_req,
    output logic         o_res_valid,
    output t_res_word    o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [CountW-1:0] r_max_messages;
    logic [SizeW-1:0]  r_max_size;
    logic              accept;
    logic              cmd_valid;
    t_cmd              cmd;
    logic [CountW-1:0] count;

    assign busy   = cmd_valid;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_messages <= MaxMessagesReset;
            r_max_size     <= MaxSizeReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_MAX_MESSAGES) begin
                r_max_messages <= pwdata[CountW-1:0];
            end else begin
                r_max_size <= pwdata[SizeW-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == ADDR_MAX_SIZE) begin
                prdata = {{(32-SizeW){1'b0}}, r_max_size};
            end else begin
                prdata = {{(32-CountW){1'b0}}, r_max_messages};
            end
        end
    end

    pmq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_req          (i_req),
        .i_max_messages (r_max_messages),
        .i_max_size     (r_max_size),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .o_count        (count)
    );

    pmq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_count     (count),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef NO_ASSERTIONS
    // A result word follows every command in the next cycle.
    a_res_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |=> o_res_valid) else $error("result strobe missing");
    // A notification never fires on a failed request.
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.notify_fire |-> o_res.status == ST_OK)
        else $error("notification on failed request");
    // The held count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.message_count <= DepthCount)
        else $error("count beyond depth");
`endif

endmodule

// File: verif/priority_message_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_message_queue_core_tb: self-checking bench of the message queue.
// Drives directed and random requests through the command port, keeps its own
// sorted queue and owner state, and compares every result word field by field.
// ----------------------------------------------------------------------------
module priority_message_queue_core_tb;
    import pmq_pkg::*;

    localparam int WatchLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req_word   i_req = '0;
    logic        o_res_valid;
    t_res_word   o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the block: sorted queue, owner and registers.
    logic [14:0]       q_prio [$];
    logic [SizeW-1:0]  q_len [$];
    logic [63:0]       q_pay [$];
    logic              own_valid;
    logic [15:0]       own_task;
    logic [6:0]        own_sig;
    logic [CountW-1:0] cap_reg;
    logic [SizeW-1:0]  size_reg;

    t_res_word pending_results [$];
    int        errors = 0;
    int        sent_words = 0;
    int        checked_words = 0;
    int        idle_cycles = 0;

    priority_message_queue_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Work out the result of one request and update the model.
    function automatic t_res_word predict_result(t_req_word rq);
        t_res_word r;
        int        pos;
        int        lim;
        r = '0;
        lim = (cap_reg > QueueDepth) ? QueueDepth : int'(cap_reg);
        case (rq.req_type)
            REQ_SEND: begin
                if (rq.priority_req >= 16'd32768) begin
                    r.status = ST_INVALID;
                end else if (rq.length > size_reg) begin
                    r.status = ST_MSGSIZE;
                end else if (q_prio.size() >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < q_prio.size() && q_prio[pos] >= rq.priority_req[14:0])
                        pos++;
                    if (q_prio.size() == 0 && own_valid) begin
                        own_valid = 1'b0;
                        if (own_sig != 0) begin
                            r.notify_fire = 1'b1;
                            r.notify_task = own_task;
                            r.notify_signal = own_sig;
                        end
                    end
                    q_prio.insert(pos, rq.priority_req[14:0]);
                    q_len.insert(pos, rq.length);
                    q_pay.insert(pos, rq.payload);
                    r.status = ST_OK;
                end
            end
            REQ_RECEIVE: begin
                if (rq.length < size_reg) begin
                    r.status = ST_MSGSIZE;
                end else if (q_prio.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_priority = q_prio.pop_front();
                    r.out_length = q_len.pop_front();
                    r.out_payload = q_pay.pop_front();
                    r.status = ST_OK;
                end
            end
            REQ_NOTIFY_REG: begin
                if (own_valid && own_task != rq.task_id) begin
                    r.status = ST_BUSY;
                end else if (rq.notify_kind == KIND_SIGNAL) begin
                    if (rq.signal_number < 1 || rq.signal_number > SigMax) begin
                        r.status = ST_INVALID;
                    end else begin
                        own_valid = 1'b1;
                        own_task = rq.task_id;
                        own_sig = rq.signal_number;
                        r.status = ST_OK;
                    end
                end else if (rq.notify_kind == KIND_NONE) begin
                    own_valid = 1'b1;
                    own_task = rq.task_id;
                    own_sig = '0;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            default: begin
                if (own_valid && own_task == rq.task_id)
                    own_valid = 1'b0;
                r.status = ST_OK;
            end
        endcase
        r.message_count = CountW'(q_prio.size());
        return r;
    endfunction

    // Send one word: wait for not busy, hold start for one accepting edge.
    task automatic send_word(t_req_word rq);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        pending_results.push_back(predict_result(rq));
        sent_words++;
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= '0;
    endtask

    // Wait until every expected word arrived, plus the pipeline latency.
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of one register, done only while the queue is idle.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        drain();
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == 3'd0) cap_reg = data[CountW-1:0];
        else size_reg = data[SizeW-1:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic t_req_word make_req(logic [1:0] kind, logic [15:0] pr,
                                           logic [SizeW-1:0] len, logic [63:0] pay,
                                           logic [15:0] tk, logic [1:0] nk,
                                           logic [6:0] sg);
        t_req_word rq;
        rq.req_type = kind; rq.priority_req = pr; rq.length = len;
        rq.payload = pay; rq.task_id = tk; rq.notify_kind = nk;
        rq.signal_number = sg;
        return rq;
    endfunction

    function automatic t_req_word random_req(int big_len);
        t_req_word rq;
        int        sel;
        rq.req_type = REQ_SEND;
        rq.priority_req = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 40));
        if ($urandom_range(0, 3) == 0) rq.priority_req[14:0] = 15'($urandom);
        rq.length = big_len ? SizeW'($urandom_range(0, 2097151))
                            : SizeW'($urandom_range(0, int'(size_reg) + 2));
        rq.payload = {$urandom, $urandom};
        rq.task_id = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) rq.task_id = 16'($urandom);
        rq.notify_kind = 2'($urandom);
        rq.signal_number = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                       : 7'($urandom_range(0, 65));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            rq.req_type = REQ_SEND;
        end else if (sel < 85) begin
            rq.req_type = REQ_RECEIVE;
            rq.length = ($urandom_range(0, 7) == 0) ? SizeW'($urandom)
                                                    : SizeW'(int'(size_reg) + $urandom_range(0, 3));
        end else if (sel < 95) begin
            rq.req_type = REQ_NOTIFY_REG;
        end else begin
            rq.req_type = REQ_NOTIFY_UNR;
        end
        return rq;
    endfunction

    // Burst sender with random gaps.
    task automatic random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_word(random_req($urandom_range(0, 20) == 0));
                burst--; left--;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    task automatic test_send_receive_order();
        send_word(make_req(REQ_RECEIVE, 0, 21'd8192, 0, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd5, 21'd0, 64'h0, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd32767, 21'd8192, '1, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd5, 21'd1, 64'hA5A5, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd0, 21'd3, 64'h1, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd32768, 21'd3, 64'h1, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'hFFFF, 21'd3, 64'h1, 0, 0, 0));
        send_word(make_req(REQ_SEND, 16'd1, 21'd8193, 64'h1, 0, 0, 0));
        send_word(make_req(REQ_RECEIVE, 0, 21'd8191, 0, 0, 0, 0));
        repeat (5) send_word(make_req(REQ_RECEIVE, '1, 21'h1FFFFF, '1, '1, '1, '1));
    endtask

    task automatic test_full_queue();
        repeat (12) send_word(make_req(REQ_SEND, 16'($urandom_range(0, 3)), 21'd4,
                                       {$urandom, $urandom}, 0, 0, 0));
        write_reg(3'd0, 32'd2);
        send_word(make_req(REQ_SEND, 16'd9, 21'd4, 64'h9, 0, 0, 0));
        repeat (11) send_word(make_req(REQ_RECEIVE, 0, 21'd8192, 0, 0, 0, 0));
        write_reg(3'd0, 32'd0);
        send_word(make_req(REQ_SEND, 16'd9, 21'd4, 64'h9, 0, 0, 0));
        write_reg(3'd0, 32'd10);
    endtask

    task automatic test_notification();
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, KIND_SIGNAL, 7'd0));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, KIND_SIGNAL, 7'd65));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, 2'd2, 7'd3));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, 2'd3, 7'd3));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, KIND_SIGNAL, 7'd64));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd8, KIND_SIGNAL, 7'd1));
        send_word(make_req(REQ_NOTIFY_UNR, 0, 0, 0, 16'd8, 0, 0));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd7, KIND_SIGNAL, 7'd1));
        send_word(make_req(REQ_SEND, 16'd2, 21'd4, 64'h2, 0, 0, 0));
        send_word(make_req(REQ_RECEIVE, 0, 21'd8192, 0, 0, 0, 0));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'hFFFF, KIND_NONE, 7'd5));
        send_word(make_req(REQ_SEND, 16'd2, 21'd4, 64'h2, 0, 0, 0));
        send_word(make_req(REQ_RECEIVE, 0, 21'd8192, 0, 0, 0, 0));
        send_word(make_req(REQ_NOTIFY_REG, 0, 0, 0, 16'd3, KIND_SIGNAL, 7'd9));
        send_word(make_req(REQ_NOTIFY_UNR, 0, 0, 0, 16'd3, 0, 0));
        send_word(make_req(REQ_SEND, 16'd2, 21'd4, 64'h2, 0, 0, 0));
        send_word(make_req(REQ_RECEIVE, 0, 21'd8192, 0, 0, 0, 0));
    endtask

    task automatic test_random_settings();
        random_phase(500);
        write_reg(3'd0, 32'd1024);
        write_reg(3'd4, 32'd1);
        random_phase(400);
        write_reg(3'd0, 32'd1);
        write_reg(3'd4, 32'd1048576);
        random_phase(300);
        write_reg(3'd0, 32'd16);
        write_reg(3'd4, 32'd64);
        random_phase(400);
        write_reg(3'd0, 32'd5);
        write_reg(3'd4, 32'd8192);
        random_phase(400);
    endtask

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        t_res_word e;
        if (i_rst_n && o_res_valid) begin
            checked_words++;
            if (pending_results.size() == 0) begin
                $error("result word with no expectation");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_res.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_res.status); errors++;
                end
                if (o_res.out_payload !== e.out_payload) begin
                    $error("out_payload exp %h got %h", e.out_payload, o_res.out_payload);
                    errors++;
                end
                if (o_res.out_priority !== e.out_priority) begin
                    $error("out_priority exp %0d got %0d", e.out_priority,
                           o_res.out_priority);
                    errors++;
                end
                if (o_res.out_length !== e.out_length) begin
                    $error("out_length exp %0d got %0d", e.out_length, o_res.out_length);
                    errors++;
                end
                if (o_res.notify_fire !== e.notify_fire) begin
                    $error("notify_fire exp %0d got %0d", e.notify_fire, o_res.notify_fire);
                    errors++;
                end
                if (o_res.notify_task !== e.notify_task) begin
                    $error("notify_task exp %0d got %0d", e.notify_task, o_res.notify_task);
                    errors++;
                end
                if (o_res.notify_signal !== e.notify_signal) begin
                    $error("notify_signal exp %0d got %0d", e.notify_signal,
                           o_res.notify_signal);
                    errors++;
                end
                if (o_res.message_count !== e.message_count) begin
                    $error("message_count exp %0d got %0d", e.message_count,
                           o_res.message_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        own_valid = 1'b0; own_task = '0; own_sig = '0;
        cap_reg = MaxMessagesReset; size_reg = MaxSizeReset;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_send_receive_order();
        test_full_queue();
        test_notification();
        test_random_settings();
        drain();
        if (pending_results.size() != 0) errors++;
        $display("Covered %0d requests and %0d result words over five register settings.",
                 sent_words, checked_words);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
